>>> rtl/mmf_pkg.sv
// Moving median filter: shared types and constants.
// No dependencies; imported by all mmf modules and the top level.
`timescale 1ns / 1ps

package mmf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WIN_W    = 4;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DONE
  } mmf_state_e;

  typedef struct packed {
    logic accept;
    logic sort_step;
    logic load_out;
  } mmf_cmd_t;

  typedef struct packed {
    logic win_ok;
    logic sort_last;
  } mmf_stat_t;

endpackage

>>> rtl/moving_median_filter.sv
// Moving median filter top level: controller plus datapath.
// Depends on mmf_pkg, mmf_ctrl and mmf_datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid_i / in_stall_o carries sample_i; output channel
//   out_valid_o / out_stall_i carries median_o. An item moves at a clock edge
//   with valid high and stall low. cfg_we_i writes cfg_wdata_i into the window
//   size register; write it only while the block is idle.
//   Each sample enters a circular store of WINDOW_LIMIT-1 entries and the
//   median of the first window-size entries is returned, one result per item.
//   A window of 0 or WINDOW_LIMIT and above returns 0 and leaves the store as is.
//   Timing: the sorter runs one odd-even transposition pass per cycle over the
//   whole store, WINDOW_LIMIT-1 passes. A valid-window item is accepted, sorted
//   and written to the output register in turn. An invalid-window item skips
//   the sort and goes straight from accept to the output register.
//   The output register lets the next item be accepted while a result waits;
//   if the receiver stalls, the following result holds in the sorter and the
//   input stalls until the output register frees.
//   Reset clears the store and write pointer and sets the window size to 8.

module moving_median_filter
  import mmf_pkg::*;
#(
  parameter int unsigned WINDOW_LIMIT = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WIN_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] median_o
);

  mmf_cmd_t  cmd;
  mmf_stat_t stat;

  mmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mmf_datapath #(
    .WINDOW_LIMIT (WINDOW_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .median_o    (median_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> rtl/mmf_ctrl.sv
// Moving median filter controller: accept / sort / deliver sequencing.
// Depends on mmf_pkg (state enum, command and status structs).
`timescale 1ns / 1ps

module mmf_ctrl
  import mmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  mmf_stat_t stat_i,
  output mmf_cmd_t  cmd_o
);

  mmf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.win_ok ? ST_SORT : ST_DONE;
        end
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (stat_i.sort_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/mmf_datapath.sv
// Moving median filter datapath: window register, sample store, write pointer,
// odd-even transposition sorter and output register. Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_datapath
  import mmf_pkg::*;
#(
  parameter int unsigned WINDOW_LIMIT = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WIN_W-1:0]    cfg_wdata_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SAMPLE_W-1:0] median_o,
  input  mmf_cmd_t            cmd_i,
  output mmf_stat_t           stat_o
);

  localparam int unsigned DEPTH = WINDOW_LIMIT - 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned LIM_W = WIN_W + 1;

  logic [WIN_W-1:0]    window_q;
  logic [WIN_W-1:0]    wptr_q, wptr_d;
  logic [WIN_W-1:0]    wptr_inc;
  logic [SAMPLE_W-1:0] store_q [DEPTH];
  logic [SAMPLE_W-1:0] work_q  [DEPTH];
  logic [SAMPLE_W-1:0] work_d  [DEPTH];
  logic [IDX_W-1:0]    pass_q;
  logic [IDX_W-1:0]    mid_idx;
  logic [SAMPLE_W-1:0] median_q;
  logic                zero_q;
  logic                win_ok;

  assign win_ok = (window_q != '0) &&
                  ({1'b0, window_q} < LIM_W'(WINDOW_LIMIT));

  assign wptr_inc = wptr_q + WIN_W'(1);
  assign wptr_d   = (wptr_inc >= window_q) ? '0 : wptr_inc;
  assign mid_idx  = IDX_W'(window_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.accept && win_ok) begin
      wptr_q                   <= wptr_d;
      store_q[IDX_W'(wptr_d)]  <= sample_i;
    end
  end

  // Load: entries outside the window are padded with the maximum value so
  // they settle at the top and leave the lower ranks untouched.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      work_d[i] = work_q[i];
    end
    if (cmd_i.accept) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= int'(window_q)) begin
          work_d[i] = '1;
        end else if (IDX_W'(i) == IDX_W'(wptr_d)) begin
          work_d[i] = sample_i;
        end else begin
          work_d[i] = store_q[i];
        end
      end
    end else if (cmd_i.sort_step) begin
      for (int i = 0; i + 1 < DEPTH; i++) begin
        if (((i % 2) == 1) == pass_q[0] && work_q[i] > work_q[i+1]) begin
          work_d[i]   = work_q[i+1];
          work_d[i+1] = work_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      work_q[i] <= work_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      zero_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pass_q <= '0;
      zero_q <= !win_ok;
    end else if (cmd_i.sort_step) begin
      pass_q <= pass_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      median_q <= zero_q ? '0 : work_q[mid_idx];
    end
  end

  assign stat_o.win_ok    = win_ok;
  assign stat_o.sort_last = (pass_q == IDX_W'(DEPTH - 1));
  assign median_o         = median_q;

endmodule
